@@ rtl/etcd_pkg.sv @@
// ----------------------------------------------------------------------------
// etcd_pkg: shared constants and helpers for the elapsed-time calendar unit
// Field widths, the constant divisors of the conversion chain, the month
// start tables and the leap-year and month lookups.
// ----------------------------------------------------------------------------
package etcd_pkg;

    // Field widths at the ports.
    localparam int unsigned W_ELAPSED = 42;
    localparam int unsigned W_YEAR    = 12;
    localparam int unsigned W_MONTH   = 4;
    localparam int unsigned W_DAY     = 5;
    localparam int unsigned W_DOY     = 9;
    localparam int unsigned W_HOUR    = 5;
    localparam int unsigned W_MINUTE  = 6;
    localparam int unsigned W_SECOND  = 6;
    localparam int unsigned W_MILLI   = 10;

    // Count of whole elapsed years; the largest input gives 139.
    localparam int unsigned W_YEARS = 8;

    localparam int unsigned BASE_YEAR = 2000;
    localparam int unsigned CENTURY   = 100;
    localparam int unsigned MONTHS    = 12;
    localparam int unsigned DECEMBER  = 12;

    localparam int unsigned       MS_PER_SECOND = 1000;
    localparam int unsigned       MS_PER_MINUTE = 60 * MS_PER_SECOND;
    localparam int unsigned       MS_PER_HOUR   = 60 * MS_PER_MINUTE;
    localparam int unsigned       MS_PER_DAY    = 24 * MS_PER_HOUR;
    localparam int unsigned       DAYS_PER_YEAR = 365;
    localparam longint unsigned   MS_PER_YEAR   = longint'(DAYS_PER_YEAR) * longint'(MS_PER_DAY);

    // Each divisor carries a power of two that is split off as a plain shift.
    // The low bits bypass the divider and are put back beside its remainder.
    // Day and year share the same power of two, so one shift serves both.
    localparam int unsigned DAY_SH    = 10;
    localparam int unsigned DAY_DIV   = MS_PER_DAY >> DAY_SH;
    localparam int unsigned YEAR_DIV  = DAYS_PER_YEAR * DAY_DIV;
    localparam int unsigned YEAR_XW   = W_ELAPSED - DAY_SH;
    localparam int unsigned YEAR_RW   = $clog2(YEAR_DIV);
    localparam int unsigned DAY_XW    = YEAR_RW;
    localparam int unsigned DAY_RW    = $clog2(DAY_DIV);
    localparam int unsigned MS_DAY_W  = DAY_RW + DAY_SH;

    localparam int unsigned HOUR_SH   = 7;
    localparam int unsigned HOUR_DIV  = MS_PER_HOUR >> HOUR_SH;
    localparam int unsigned HOUR_XW   = MS_DAY_W - HOUR_SH;
    localparam int unsigned HOUR_RW   = $clog2(HOUR_DIV);
    localparam int unsigned MS_HOUR_W = HOUR_RW + HOUR_SH;

    localparam int unsigned MIN_SH    = 5;
    localparam int unsigned MIN_DIV   = MS_PER_MINUTE >> MIN_SH;
    localparam int unsigned MIN_XW    = MS_HOUR_W - MIN_SH;
    localparam int unsigned MIN_RW    = $clog2(MIN_DIV);
    localparam int unsigned MS_MIN_W  = MIN_RW + MIN_SH;

    localparam int unsigned SEC_SH    = 3;
    localparam int unsigned SEC_DIV   = MS_PER_SECOND >> SEC_SH;
    localparam int unsigned SEC_XW    = MS_MIN_W - SEC_SH;
    localparam int unsigned SEC_RW    = $clog2(SEC_DIV);

    // First zero-based day of each month.
    localparam logic [W_DOY-1:0] CUM_COMMON [MONTHS] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };
    localparam logic [W_DOY-1:0] CUM_LEAP [MONTHS] = '{
        9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152,
        9'd182, 9'd213, 9'd244, 9'd274, 9'd305, 9'd335
    };

    typedef struct packed {
        logic [W_MONTH-1:0] month;
        logic [W_DAY-1:0]   dom;
    } t_month_day;

    // The elapsed-year count stays below 256 and 2000 is a multiple of 400,
    // so the only centuries that are not leap years are 100 and 200.
    function automatic logic is_leap(input logic [W_YEARS-1:0] years);
        return (years[1:0] == 2'b00)
            && (years != W_YEARS'(CENTURY))
            && (years != W_YEARS'(2 * CENTURY));
    endfunction

    // Month is the number of later month starts that the day has reached,
    // capped at December; in a leap year December 31 never comes up.
    function automatic t_month_day month_of(input logic [W_DOY-1:0] doy, input logic leap);
        t_month_day           res;
        logic [W_MONTH-1:0]   idx;
        logic [W_DOY-1:0]     start;
        idx = '0;
        for (int k = 1; k < MONTHS; k++) begin
            if (doy >= (leap ? CUM_LEAP[k] : CUM_COMMON[k])) begin
                idx = idx + W_MONTH'(1);
            end
        end
        start     = leap ? CUM_LEAP[idx] : CUM_COMMON[idx];
        res.month = idx + W_MONTH'(1);
        res.dom   = W_DAY'(doy - start + W_DOY'(1));
        return res;
    endfunction

endpackage

@@ rtl/elapsed_time_to_calendar_date_unit.sv @@
// ----------------------------------------------------------------------------
// elapsed_time_to_calendar_date_unit: milliseconds since 2000 to calendar date
// Splits an elapsed millisecond count into year, month, day of month, day of
// year, hour, minute, second and millisecond, with a leap-year flag. Every
// year counts as 365 days; the leap rule only selects the month table.
//
// Usage: the input channel (i_valid, o_stall, i_elapsed_ms) takes one item
// per transfer. The result channel (o_valid, i_stall and the o_ fields)
// gives exactly one result for each input, in order.
// Throughput is one item per clock cycle while not stalled. Items pass the
// input register, five dividers by a constant in a chain (year, day, hour,
// minute, second) of two register stages each, and the result register.
// The whole pipeline moves as one; when the receiver holds i_stall while a
// result is shown, every stage and the result hold still and o_stall rises
// in the same cycle. Bubbles pass through freely while the output drains.
// A synchronous reset (i_rst_n low) empties the pipeline; data registers
// keep their contents but are never shown without a valid.
// ----------------------------------------------------------------------------
module elapsed_time_to_calendar_date_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [etcd_pkg::W_ELAPSED-1:0]    i_elapsed_ms,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [etcd_pkg::W_YEAR-1:0]       o_year_number,
    output logic [etcd_pkg::W_MONTH-1:0]      o_month_number,
    output logic [etcd_pkg::W_DAY-1:0]        o_day_of_month,
    output logic [etcd_pkg::W_DOY-1:0]        o_day_of_year,
    output logic [etcd_pkg::W_HOUR-1:0]       o_hour_of_day,
    output logic [etcd_pkg::W_MINUTE-1:0]     o_minute_of_hour,
    output logic [etcd_pkg::W_SECOND-1:0]     o_second_of_minute,
    output logic [etcd_pkg::W_MILLI-1:0]      o_millisecond_part,
    output logic                              o_leap_flag
);

    // Stage 0 is the input register, stage 11 the result register.
    localparam int unsigned LAST = 11;

    logic [LAST:0] r_v;
    logic          w_en;

    // Stage 0.
    logic [etcd_pkg::W_ELAPSED-1:0] r_t;

    // Values that travel alongside the divider chain, indexed by stage.
    logic [etcd_pkg::DAY_SH-1:0]   r_tlo   [1:4];
    logic [etcd_pkg::W_YEARS-1:0]  r_years [3:10];
    logic                          r_leap  [3:10];
    logic [etcd_pkg::W_DOY-1:0]    r_doy   [5:10];
    etcd_pkg::t_month_day          r_md    [5:10];
    logic [etcd_pkg::HOUR_SH-1:0]  r_ms7   [5:6];
    logic [etcd_pkg::W_HOUR-1:0]   r_hour  [7:10];
    logic [etcd_pkg::MIN_SH-1:0]   r_ms5   [7:8];
    logic [etcd_pkg::W_MINUTE-1:0] r_minute[9:10];
    logic [etcd_pkg::SEC_SH-1:0]   r_ms3   [9:10];

    // Divider outputs and the reassembled remainders.
    logic [etcd_pkg::W_YEARS-1:0]   w_years;
    logic [etcd_pkg::YEAR_RW-1:0]   w_rem1;
    logic [etcd_pkg::W_DOY-1:0]     w_doy;
    logic [etcd_pkg::DAY_RW-1:0]    w_rem2;
    logic [etcd_pkg::MS_DAY_W-1:0]  w_ms_day;
    logic [etcd_pkg::W_HOUR-1:0]    w_hour;
    logic [etcd_pkg::HOUR_RW-1:0]   w_rem3;
    logic [etcd_pkg::MS_HOUR_W-1:0] w_ms_hour;
    logic [etcd_pkg::W_MINUTE-1:0]  w_minute;
    logic [etcd_pkg::MIN_RW-1:0]    w_rem4;
    logic [etcd_pkg::MS_MIN_W-1:0]  w_ms_min;
    logic [etcd_pkg::W_SECOND-1:0]  w_second;
    logic [etcd_pkg::SEC_RW-1:0]    w_rem5;
    logic [etcd_pkg::W_MILLI-1:0]   w_milli;

    // Result register.
    logic [etcd_pkg::W_YEAR-1:0]    r_year_number;
    logic [etcd_pkg::W_MONTH-1:0]   r_month_number;
    logic [etcd_pkg::W_DAY-1:0]     r_day_of_month;
    logic [etcd_pkg::W_DOY-1:0]     r_day_of_year;
    logic [etcd_pkg::W_HOUR-1:0]    r_hour_of_day;
    logic [etcd_pkg::W_MINUTE-1:0]  r_minute_of_hour;
    logic [etcd_pkg::W_SECOND-1:0]  r_second_of_minute;
    logic [etcd_pkg::W_MILLI-1:0]   r_millisecond_part;
    logic                           r_leap_flag;

    // The pipeline advances unless a finished result is being held back.
    assign w_en    = !(r_v[LAST] && i_stall);
    assign o_stall = r_v[LAST] && i_stall;
    assign o_valid = r_v[LAST];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[LAST-1:0], i_valid};
        end
    end

    // Whole years: the input shifted right by the common power of two,
    // divided by the odd part of the year length.
    etcd_cdiv #(
        .XW  (etcd_pkg::YEAR_XW),
        .QW  (etcd_pkg::W_YEARS),
        .DIV (etcd_pkg::YEAR_DIV)
    ) u_year_div (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_x   (r_t[etcd_pkg::W_ELAPSED-1:etcd_pkg::DAY_SH]),
        .o_q   (w_years),
        .o_r   (w_rem1)
    );

    // Day of year from the shifted remainder of the year.
    etcd_cdiv #(
        .XW  (etcd_pkg::DAY_XW),
        .QW  (etcd_pkg::W_DOY),
        .DIV (etcd_pkg::DAY_DIV)
    ) u_day_div (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_x   (w_rem1),
        .o_q   (w_doy),
        .o_r   (w_rem2)
    );

    // Milliseconds into the day: the day remainder with the low input bits
    // that skipped both dividers put back underneath.
    assign w_ms_day = {w_rem2, r_tlo[4]};

    etcd_cdiv #(
        .XW  (etcd_pkg::HOUR_XW),
        .QW  (etcd_pkg::W_HOUR),
        .DIV (etcd_pkg::HOUR_DIV)
    ) u_hour_div (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_x   (w_ms_day[etcd_pkg::MS_DAY_W-1:etcd_pkg::HOUR_SH]),
        .o_q   (w_hour),
        .o_r   (w_rem3)
    );

    assign w_ms_hour = {w_rem3, r_ms7[6]};

    etcd_cdiv #(
        .XW  (etcd_pkg::MIN_XW),
        .QW  (etcd_pkg::W_MINUTE),
        .DIV (etcd_pkg::MIN_DIV)
    ) u_minute_div (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_x   (w_ms_hour[etcd_pkg::MS_HOUR_W-1:etcd_pkg::MIN_SH]),
        .o_q   (w_minute),
        .o_r   (w_rem4)
    );

    assign w_ms_min = {w_rem4, r_ms5[8]};

    etcd_cdiv #(
        .XW  (etcd_pkg::SEC_XW),
        .QW  (etcd_pkg::W_SECOND),
        .DIV (etcd_pkg::SEC_DIV)
    ) u_second_div (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_x   (w_ms_min[etcd_pkg::MS_MIN_W-1:etcd_pkg::SEC_SH]),
        .o_q   (w_second),
        .o_r   (w_rem5)
    );

    assign w_milli = {w_rem5, r_ms3[10]};

    // Side registers move with the valid bits; none of them needs a reset.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_t <= i_elapsed_ms;

            r_tlo[1] <= r_t[etcd_pkg::DAY_SH-1:0];
            for (int k = 2; k <= 4; k++) begin
                r_tlo[k] <= r_tlo[k-1];
            end

            // The leap flag is worked out as soon as the year count is known,
            // ahead of the month lookup that needs it.
            r_years[3] <= w_years;
            r_leap[3]  <= etcd_pkg::is_leap(w_years);
            for (int k = 4; k <= 10; k++) begin
                r_years[k] <= r_years[k-1];
                r_leap[k]  <= r_leap[k-1];
            end

            r_doy[5] <= w_doy;
            r_md[5]  <= etcd_pkg::month_of(w_doy, r_leap[4]);
            for (int k = 6; k <= 10; k++) begin
                r_doy[k] <= r_doy[k-1];
                r_md[k]  <= r_md[k-1];
            end

            r_ms7[5] <= w_ms_day[etcd_pkg::HOUR_SH-1:0];
            r_ms7[6] <= r_ms7[5];

            r_hour[7] <= w_hour;
            for (int k = 8; k <= 10; k++) begin
                r_hour[k] <= r_hour[k-1];
            end

            r_ms5[7] <= w_ms_hour[etcd_pkg::MIN_SH-1:0];
            r_ms5[8] <= r_ms5[7];

            r_minute[9]  <= w_minute;
            r_minute[10] <= r_minute[9];

            r_ms3[9]  <= w_ms_min[etcd_pkg::SEC_SH-1:0];
            r_ms3[10] <= r_ms3[9];

            r_year_number      <= etcd_pkg::W_YEAR'(r_years[10])
                                + etcd_pkg::W_YEAR'(etcd_pkg::BASE_YEAR);
            r_month_number     <= r_md[10].month;
            r_day_of_month     <= r_md[10].dom;
            r_day_of_year      <= r_doy[10];
            r_hour_of_day      <= r_hour[10];
            r_minute_of_hour   <= r_minute[10];
            r_second_of_minute <= w_second;
            r_millisecond_part <= w_milli;
            r_leap_flag        <= r_leap[10];
        end
    end

    assign o_year_number      = r_year_number;
    assign o_month_number     = r_month_number;
    assign o_day_of_month     = r_day_of_month;
    assign o_day_of_year      = r_day_of_year;
    assign o_hour_of_day      = r_hour_of_day;
    assign o_minute_of_hour   = r_minute_of_hour;
    assign o_second_of_minute = r_second_of_minute;
    assign o_millisecond_part = r_millisecond_part;
    assign o_leap_flag        = r_leap_flag;

endmodule

@@ rtl/etcd_cdiv.sv @@
// ----------------------------------------------------------------------------
// etcd_cdiv: two-stage divider by a constant
// Quotient estimate by multiplication with a truncated reciprocal, then one
// correction step on the remainder. The dividend and the estimate are
// registered in the first stage, quotient and remainder in the second.
// ----------------------------------------------------------------------------
module etcd_cdiv #(
    parameter int unsigned XW  = etcd_pkg::SEC_XW,
    parameter int unsigned QW  = etcd_pkg::W_SECOND,
    parameter int unsigned DIV = etcd_pkg::SEC_DIV
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [XW-1:0]            i_x,
    output logic [QW-1:0]            o_q,
    output logic [$clog2(DIV)-1:0]   o_r
);

    // With the dividend below 2**XW the estimate is low by at most one.
    localparam longint unsigned M_VAL = (64'd1 << XW) / DIV;
    localparam int unsigned     MW    = $clog2(M_VAL + 1);
    localparam int unsigned     RW    = $clog2(DIV);
    localparam int unsigned     PW    = XW + MW;
    localparam logic [MW-1:0]   M_REC = MW'(M_VAL);
    localparam logic [XW-1:0]   DIV_X = XW'(DIV);

    logic [PW-1:0] w_prod;
    logic [XW-1:0] r_x;
    logic [QW-1:0] r_q0;
    logic [XW-1:0] w_qd;
    logic [XW-1:0] w_r0;
    logic          w_ge;
    logic [QW-1:0] n_q;
    logic [RW-1:0] n_r;
    logic [QW-1:0] r_q;
    logic [RW-1:0] r_r;

    assign w_prod = PW'(i_x) * PW'(M_REC);

    always_comb begin
        w_qd = XW'(r_q0) * DIV_X;
        w_r0 = r_x - w_qd;
        w_ge = (w_r0 >= DIV_X);
        n_q  = r_q0 + QW'(w_ge);
        n_r  = w_ge ? RW'(w_r0 - DIV_X) : RW'(w_r0);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x  <= i_x;
            r_q0 <= w_prod[XW +: QW];
            r_q  <= n_q;
            r_r  <= n_r;
        end
    end

    assign o_q = r_q;
    assign o_r = r_r;

endmodule

@@ rtl/etcd_chk.sv @@
// ----------------------------------------------------------------------------
// etcd_chk: port-level checks for the elapsed-time calendar unit
// Watches the ports of the top level and is attached to it by a bind.
// ----------------------------------------------------------------------------
module etcd_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_valid,
    input logic                              o_stall,
    input logic [etcd_pkg::W_ELAPSED-1:0]    i_elapsed_ms,
    input logic                              o_valid,
    input logic                              i_stall,
    input logic [etcd_pkg::W_YEAR-1:0]       o_year_number,
    input logic [etcd_pkg::W_MONTH-1:0]      o_month_number,
    input logic [etcd_pkg::W_DAY-1:0]        o_day_of_month,
    input logic [etcd_pkg::W_DOY-1:0]        o_day_of_year,
    input logic [etcd_pkg::W_HOUR-1:0]       o_hour_of_day,
    input logic [etcd_pkg::W_MINUTE-1:0]     o_minute_of_hour,
    input logic [etcd_pkg::W_SECOND-1:0]     o_second_of_minute,
    input logic [etcd_pkg::W_MILLI-1:0]      o_millisecond_part,
    input logic                              o_leap_flag
);

    // Reset empties the pipeline, so nothing is shown on the next cycle.
    a_reset_empties : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result shown right after reset");

    // A result that is held back keeps all of its fields.
    a_hold_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable({o_year_number, o_month_number,
            o_day_of_month, o_day_of_year, o_hour_of_day, o_minute_of_hour,
            o_second_of_minute, o_millisecond_part, o_leap_flag}))
        else $error("held result changed");

    // The input side only waits while a finished result is held back.
    a_stall_only_when_held : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a held result");

    // The leap flag agrees with the calendar year shown beside it.
    a_leap_matches_year : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_leap_flag == ((o_year_number[1:0] == 2'b00)
            && (o_year_number != etcd_pkg::W_YEAR'(etcd_pkg::BASE_YEAR + etcd_pkg::CENTURY))
            && (o_year_number != etcd_pkg::W_YEAR'(etcd_pkg::BASE_YEAR
                + 2 * etcd_pkg::CENTURY))))
        else $error("leap flag does not match year");

    // With a 365-day year, a leap year ends on December 30.
    a_no_last_leap_day : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_leap_flag |->
            !((o_month_number == etcd_pkg::W_MONTH'(etcd_pkg::DECEMBER))
              && (o_day_of_month == etcd_pkg::W_DAY'(31))))
        else $error("December 31 shown in a leap year");

endmodule

bind elapsed_time_to_calendar_date_unit etcd_chk u_etcd_chk (.*);
